// ===== src/sqlf_pkg.sv =====
// ============================================================================
// sqlf_pkg - shared types and constants of the read-only SQL statement filter
// Holds the cleaned-text event codes, the queue entry layout, the statement
// keyword table and the verdict and statement type codes.
// ============================================================================
package sqlf_pkg;

    // default length of the first-token buffer
    localparam int KEYWORD_CHARS_DEF = 6;

    // byte fields on the stream ports
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 4;
    localparam int TDATA_W = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // statement keyword table
    localparam int KW_COUNT   = 10;
    localparam int KW_MAX_LEN = 6;
    localparam int KW_LEN_W   = 3;

    localparam logic [BYTE_W-1:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"S", "E", "L", "E", "C", "T"},
        '{"I", "N", "S", "E", "R", "T"},
        '{"U", "P", "D", "A", "T", "E"},
        '{"D", "E", "L", "E", "T", "E"},
        '{"C", "R", "E", "A", "T", "E"},
        '{"D", "R", "O", "P", 8'h00, 8'h00},
        '{"A", "L", "T", "E", "R", 8'h00},
        '{"P", "R", "A", "G", "M", "A"},
        '{"A", "T", "T", "A", "C", "H"},
        '{"D", "E", "T", "A", "C", "H"}
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6
    };

    // statement type codes
    localparam logic [CODE_W-1:0] TYPE_SELECT  = 4'd0;
    localparam logic [CODE_W-1:0] TYPE_UNKNOWN = 4'd10;

    // verdict codes (forbidden types are type + 1)
    localparam logic [CODE_W-1:0] VERDICT_VALID     = 4'd0;
    localparam logic [CODE_W-1:0] VERDICT_EMPTY     = 4'd1;
    localparam logic [CODE_W-1:0] VERDICT_UNKNOWN   = 4'd11;
    localparam logic [CODE_W-1:0] VERDICT_INJECTION = 4'd12;

    // special characters
    localparam logic [BYTE_W-1:0] CH_SEMI  = ";";
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_DASH  = "-";
    localparam logic [BYTE_W-1:0] CH_SLASH = "/";
    localparam logic [BYTE_W-1:0] CH_STAR  = "*";

    // one event of the cleaned text
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SPACE = 2'd1,
        EV_CHAR  = 2'd2
    } ev_kind_t;

    // queue entry: up to two cleaned-text events per input beat
    typedef struct packed {
        ev_kind_t            kind0;
        logic [BYTE_W-1:0]   data0;
        ev_kind_t            kind1;
        logic [BYTE_W-1:0]   data1;
        logic                last;
        logic                raw_nonempty;
    } entry_t;

endpackage

// ===== src/sql_readonly_statement_filter_core.sv =====
// ============================================================================
// sql_readonly_statement_filter_core - read-only SQL statement filter
// Takes a query one byte per beat, strips comments, folds whitespace,
// classifies the first token and gives one verdict beat per query.
// ============================================================================
//
//  channel  | dir | tdata bits (low first)                      | tlast
//  ---------+-----+---------------------------------------------+---------------
//  s_axis   | in  | query_char[7:0], char_present[8], zero fill | end of query
//  m_axis   | out | verdict[3:0], statement_type[7:4],          | none
//           |     | read_only[8], zero fill                     |
//
//  one input beat per cycle while s_tready is high; the front end decides
//  each beat combinationally and the back end takes one queue entry per
//  cycle while no tlast entry waits; the verdict passes the queue, then the
//  output register, later only while an earlier verdict waits on m_tready
//  rst_n clears comment, token and handshake state at once; no clearing pass
//  while a verdict waits on m_tready the next tlast entry waits at the queue
//  head; one more beat fits behind it, then s_tready drops
//
module sql_readonly_statement_filter_core #(
    parameter int KEYWORD_CHARS = sqlf_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sqlf_pkg::TDATA_W-1:0]  s_tdata,   // query_char, char_present
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sqlf_pkg::TDATA_W-1:0]  m_tdata    // verdict, statement_type, read_only
);
    import sqlf_pkg::*;

    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;
    logic   beat_ok;
    entry_t front_entry;
    entry_t q_head;

    assign s_tready = !q_full;
    assign beat_ok  = s_tvalid && s_tready;

    // comment stripping and lookahead
    sqlf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat_ok      (beat_ok),
        .query_char   (s_tdata[BYTE_W-1:0]),
        .char_present (s_tdata[BYTE_W]),
        .last         (s_tlast),
        .entry        (front_entry)
    );

    // decoupling queue
    sqlf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (beat_ok),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .not_empty (q_not_empty)
    );

    // token capture and verdict
    sqlf_back #(
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== src/sqlf_front.sv =====
// ============================================================================
// sqlf_front - comment stripping front end
// Holds one byte of lookahead, tracks line and block comments and turns each
// input beat into at most two cleaned-text events for the back end.
// ============================================================================
module sqlf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          beat_ok,
    input  logic [sqlf_pkg::BYTE_W-1:0]   query_char,
    input  logic                          char_present,
    input  logic                          last,
    output sqlf_pkg::entry_t              entry
);
    import sqlf_pkg::*;

    typedef struct packed {
        logic              line;
        logic              block;
        logic              skip;
        ev_kind_t          kind;
    } scan_t;

    logic [BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              line_reg, line_next;
    logic              block_reg, block_next;
    logic              raw_reg, raw_next;

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) ||
               (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);
    endfunction

    // classify one byte given its lookahead
    function automatic scan_t scan(input logic [BYTE_W-1:0] c,
                                   input logic [BYTE_W-1:0] nx,
                                   input logic              nx_valid,
                                   input logic              line_in,
                                   input logic              block_in);
        scan_t r;
        r.line  = line_in;
        r.block = block_in;
        r.skip  = 1'b0;
        r.kind  = EV_NONE;
        if (block_in) begin
            if (c == CH_STAR && nx_valid && nx == CH_SLASH) begin
                r.block = 1'b0;
                r.skip  = 1'b1;
            end
        end else if (line_in) begin
            if (c == CH_LF)
                r.line = 1'b0;
        end else if (c == CH_DASH && nx_valid && nx == CH_DASH) begin
            r.line = 1'b1;
        end else if (c == CH_SLASH && nx_valid && nx == CH_STAR) begin
            r.block = 1'b1;
            r.skip  = 1'b1;
        end else if (is_ws(c)) begin
            r.kind = EV_SPACE;
        end else begin
            r.kind = EV_CHAR;
        end
        return r;
    endfunction

    // next state and events for the current beat
    always_comb
    begin
        scan_t s0;
        scan_t s1;
        s0 = '0;
        s1 = '0;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        line_next       = line_reg;
        block_next      = block_reg;
        raw_next        = raw_reg;
        entry.kind0     = EV_NONE;
        entry.data0     = pend_byte_reg;
        entry.kind1     = EV_NONE;
        entry.data1     = query_char;
        entry.last      = last;

        if (char_present) begin
            raw_next = 1'b1;
            if (pend_valid_reg) begin
                s0          = scan(pend_byte_reg, query_char, 1'b1, line_reg, block_reg);
                entry.kind0 = s0.kind;
                line_next   = s0.line;
                block_next  = s0.block;
            end
            if (s0.skip) begin
                pend_valid_next = 1'b0;
            end else begin
                pend_byte_next  = query_char;
                pend_valid_next = 1'b1;
            end
        end

        // flush the lookahead byte at the end of the query
        if (last && pend_valid_next) begin
            s1          = scan(pend_byte_next, '0, 1'b0, line_next, block_next);
            entry.kind1 = s1.kind;
            entry.data1 = pend_byte_next;
        end
        entry.raw_nonempty = raw_next;

        if (last) begin
            pend_valid_next = 1'b0;
            line_next       = 1'b0;
            block_next      = 1'b0;
            raw_next        = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            line_reg       <= 1'b0;
            block_reg      <= 1'b0;
            raw_reg        <= 1'b0;
        end else if (beat_ok) begin
            pend_valid_reg <= pend_valid_next;
            line_reg       <= line_next;
            block_reg      <= block_next;
            raw_reg        <= raw_next;
        end
    end

    // lookahead byte
    always_ff @(posedge clk)
    begin
        if (beat_ok)
            pend_byte_reg <= pend_byte_next;
    end

endmodule

// ===== src/sqlf_queue.sv =====
// ============================================================================
// sqlf_queue - short queue between front and back
// A small circular buffer of event entries so that front and back can stall
// independently.
// ============================================================================
module sqlf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sqlf_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output sqlf_pkg::entry_t  pop_data,
    output logic              not_empty
);
    import sqlf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // pointer wrap
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== src/sqlf_back.sv =====
// ============================================================================
// sqlf_back - token collector and classifier
// Folds whitespace, captures the first token, watches for text after the
// first semicolon and forms the verdict into the output register.
// ============================================================================
module sqlf_back #(
    parameter int KEYWORD_CHARS = sqlf_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    input  sqlf_pkg::entry_t              q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sqlf_pkg::TDATA_W-1:0]  m_tdata
);
    import sqlf_pkg::*;

    localparam int LW = $clog2(KEYWORD_CHARS + 1);
    localparam int IW = $clog2(KEYWORD_CHARS);

    logic [BYTE_W-1:0] tok_reg [KEYWORD_CHARS];
    logic [BYTE_W-1:0] tok_next [KEYWORD_CHARS];
    logic [LW-1:0]     len_reg, len_next;
    logic              owed_reg, owed_next;
    logic              any_reg, any_next;
    logic              ovf_reg, ovf_next;
    logic              closed_reg, closed_next;
    logic              semi_reg, semi_next;
    logic              after_reg, after_next;

    logic              out_valid_reg;
    logic [CODE_W-1:0] verdict_reg, verdict_next;
    logic [CODE_W-1:0] type_reg, type_next;
    logic              ro_reg, ro_next;

    ev_kind_t          ev_kind [2];
    logic [BYTE_W-1:0] ev_data [2];

    assign ev_kind[0] = q_data.kind0;
    assign ev_kind[1] = q_data.kind1;
    assign ev_data[0] = q_data.data0;
    assign ev_data[1] = q_data.data1;

    // a last entry waits until the output register is free
    assign q_pop = q_not_empty && (!q_data.last || !out_valid_reg || m_tready);

    // apply the two events of the entry in order
    always_comb
    begin
        logic [BYTE_W-1:0] c;
        tok_next    = tok_reg;
        len_next    = len_reg;
        owed_next   = owed_reg;
        any_next    = any_reg;
        ovf_next    = ovf_reg;
        closed_next = closed_reg;
        semi_next   = semi_reg;
        after_next  = after_reg;
        for (int e = 0; e < 2; e++) begin
            c = ev_data[e];
            case (ev_kind[e])
                EV_SPACE:
                begin
                    if (any_next)
                        owed_next = 1'b1;
                end
                EV_CHAR:
                begin
                    if (owed_next) begin
                        closed_next = 1'b1;
                        owed_next   = 1'b0;
                    end
                    if (!closed_next) begin
                        if (len_next < LW'(KEYWORD_CHARS)) begin
                            tok_next[len_next[IW-1:0]] =
                                (c >= "a" && c <= "z") ? c - 8'd32 : c;
                            len_next = len_next + LW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (semi_next)
                        after_next = 1'b1;
                    if (c == CH_SEMI)
                        semi_next = 1'b1;
                    any_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // keyword match and verdict
    always_comb
    begin
        logic hit;
        logic [CODE_W-1:0] kind;
        kind = TYPE_UNKNOWN;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len_next == LW'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (KW_LEN[k] > KW_LEN_W'(i) && tok_next[i] != KW_TEXT[k][i])
                    hit = 1'b0;
            end
            if (hit && !ovf_next)
                kind = CODE_W'(k);
        end

        if (!q_data.raw_nonempty) begin
            type_next    = TYPE_UNKNOWN;
            verdict_next = VERDICT_EMPTY;
        end else begin
            type_next = kind;
            if (kind == TYPE_SELECT)
                verdict_next = after_next ? VERDICT_INJECTION : VERDICT_VALID;
            else if (kind == TYPE_UNKNOWN)
                verdict_next = VERDICT_UNKNOWN;
            else
                verdict_next = kind + CODE_W'(1);
        end
        ro_next = q_data.raw_nonempty && (kind == TYPE_SELECT);
    end

    // token and flag state, cleared after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg    <= '0;
            owed_reg   <= 1'b0;
            any_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b0;
            semi_reg   <= 1'b0;
            after_reg  <= 1'b0;
        end else if (q_pop) begin
            if (q_data.last) begin
                len_reg    <= '0;
                owed_reg   <= 1'b0;
                any_reg    <= 1'b0;
                ovf_reg    <= 1'b0;
                closed_reg <= 1'b0;
                semi_reg   <= 1'b0;
                after_reg  <= 1'b0;
            end else begin
                len_reg    <= len_next;
                owed_reg   <= owed_next;
                any_reg    <= any_next;
                ovf_reg    <= ovf_next;
                closed_reg <= closed_next;
                semi_reg   <= semi_next;
                after_reg  <= after_next;
            end
        end
    end

    // token bytes, read only below the token length
    always_ff @(posedge clk)
    begin
        if (q_pop)
            tok_reg <= tok_next;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop && q_data.last)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.last) begin
            verdict_reg <= verdict_next;
            type_reg    <= type_next;
            ro_reg      <= ro_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - 2 * CODE_W - 1)'(0), ro_reg, type_reg, verdict_reg};

endmodule

// ===== src/sqlf_checker.sv =====
// ============================================================================
// sqlf_checker - port-level checks of the statement filter
// Watches the verdict stream for held beats and consistent code pairs.
// ============================================================================
module sqlf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sqlf_pkg::TDATA_W-1:0]  m_tdata
);
    import sqlf_pkg::*;

    logic [CODE_W-1:0] verdict;
    logic [CODE_W-1:0] stype;
    logic              ro;

    assign verdict = m_tdata[CODE_W-1:0];
    assign stype   = m_tdata[2*CODE_W-1:CODE_W];
    assign ro      = m_tdata[2*CODE_W];

    // a stalled verdict beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict beat changed while stalled");

    // read_only only with a select verdict
    a_ro_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (ro == ((verdict == VERDICT_VALID) || (verdict == VERDICT_INJECTION))))
        else $error("read_only disagrees with verdict");

    // read_only only for a select statement
    a_ro_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ro |-> stype == TYPE_SELECT)
        else $error("read_only set on a non-select type");

    // empty query carries the unknown type
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (verdict == VERDICT_EMPTY) |-> stype == TYPE_UNKNOWN && !ro)
        else $error("empty verdict with a known type");

    // forbidden verdicts track the type code
    a_forbidden: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (verdict > VERDICT_EMPTY) && (verdict < VERDICT_UNKNOWN)
        |-> verdict == stype + CODE_W'(1))
        else $error("forbidden verdict does not match type");

endmodule

bind sql_readonly_statement_filter_core sqlf_checker u_sqlf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - read-only SQL statement filter
// Streams SQL query text into the filter one byte per beat. A model of the
// comment stripping, whitespace folding and first-token match computes the
// verdict of each query. Every verdict beat is checked field by field.
// ============================================================================
module testbench;

    import sqlf_pkg::*;

    localparam int TOKEN_CAP    = KEYWORD_CHARS_DEF;
    localparam int RANDOM_BEATS = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;

    // byte values beyond those in the package
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_Z = "z";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       present;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [CODE_W-1:0] verdict;
        logic [CODE_W-1:0] stype;
        logic              ro;
    } query_verdict_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;

    sql_readonly_statement_filter_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // stimulus and expectation stores
    beat_t          pending_beats[$];
    query_verdict_t expected_verdicts[$];
    logic [7:0]     query_bytes[$];

    string      kw_words [KW_COUNT] = '{"SELECT", "INSERT", "UPDATE", "DELETE", "CREATE",
                                        "DROP", "ALTER", "PRAGMA", "ATTACH", "DETACH"};
    logic [7:0] blank_bytes [6] = '{CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    string      note_chars = "ab*/-; xZ";

    int queries;
    int real_beats;
    int ignored_beats;
    int mismatch_count;
    int cycle_count;
    int verdict_hits [16];

    // driver state
    bit         beat_taken;
    int         burst_left;
    int         gap_left;
    beat_t      next_beat;
    logic [15:0] stall_bits;
    int         stall_phase;
    int         stall_age;

    // filter model state
    logic [7:0] look_byte;
    bit         look_valid;
    bit         drop_look;
    bit         in_line_note;
    bit         in_block_note;
    bit         space_due;
    bit         text_started;
    logic [7:0] token_chars [TOKEN_CAP];
    int         token_len;
    bit         token_long;
    bit         token_done;
    bit         semi_seen;
    bit         text_after_semi;
    bit         bytes_seen;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_query();
        look_byte       = 8'h00;
        look_valid      = 0;
        drop_look       = 0;
        in_line_note    = 0;
        in_block_note   = 0;
        space_due       = 0;
        text_started    = 0;
        for (int i = 0; i < TOKEN_CAP; i++)
            token_chars[i] = 8'h00;
        token_len       = 0;
        token_long      = 0;
        token_done      = 0;
        semi_seen       = 0;
        text_after_semi = 0;
        bytes_seen      = 0;
    endtask

    // one raw byte with its lookahead through comment and space handling
    task automatic fold_byte(input logic [7:0] c, input logic [7:0] nx, input bit has_nx);
        if (in_block_note)
        begin
            if (c == CH_STAR && has_nx && nx == CH_SLASH)
            begin
                in_block_note = 0;
                drop_look     = 1;
            end
        end
        else if (in_line_note)
        begin
            if (c == CH_LF)
                in_line_note = 0;
        end
        else if (c == CH_DASH && has_nx && nx == CH_DASH)
            in_line_note = 1;
        else if (c == CH_SLASH && has_nx && nx == CH_STAR)
        begin
            in_block_note = 1;
            drop_look     = 1;
        end
        else if (c inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR})
        begin
            if (text_started)
                space_due = 1;
        end
        else
        begin
            // a folded space ends the first token
            if (space_due)
            begin
                token_done = 1;
                space_due  = 0;
            end
            if (!token_done)
            begin
                if (token_len < TOKEN_CAP)
                begin
                    token_chars[token_len] = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_BIT : c;
                    token_len++;
                end
                else
                    token_long = 1;
            end
            if (semi_seen)
                text_after_semi = 1;
            if (c == CH_SEMI)
                semi_seen = 1;
            text_started = 1;
        end
    endtask

    // one accepted input beat; a beat with last yields the expected verdict
    task automatic classify_beat(input logic [7:0] c, input bit present, input bit is_last);
        query_verdict_t v;
        logic [CODE_W-1:0] kind;
        bit hit;
        if (present)
        begin
            bytes_seen = 1;
            if (look_valid)
            begin
                fold_byte(look_byte, c, 1);
                look_valid = 0;
            end
            if (drop_look)
                drop_look = 0;
            else
            begin
                look_byte  = c;
                look_valid = 1;
            end
        end
        if (is_last)
        begin
            if (look_valid)
            begin
                fold_byte(look_byte, 8'h00, 0);
                look_valid = 0;
            end
            // first token against the keyword table
            kind = TYPE_UNKNOWN;
            if (!token_long)
            begin
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (kind == TYPE_UNKNOWN && token_len == int'(KW_LEN[k]))
                    begin
                        hit = 1;
                        for (int i = 0; i < token_len; i++)
                            if (token_chars[i] != KW_TEXT[k][i])
                                hit = 0;
                        if (hit)
                            kind = CODE_W'(k);
                    end
                end
            end
            if (!bytes_seen)
            begin
                v.stype   = TYPE_UNKNOWN;
                v.verdict = VERDICT_EMPTY;
            end
            else
            begin
                v.stype = kind;
                if (kind == TYPE_SELECT)
                    v.verdict = text_after_semi ? VERDICT_INJECTION : VERDICT_VALID;
                else if (kind == TYPE_UNKNOWN)
                    v.verdict = VERDICT_UNKNOWN;
                else
                    v.verdict = kind + 4'd1;
            end
            v.ro = bytes_seen && kind == TYPE_SELECT;
            expected_verdicts.push_back(v);
            clear_query();
        end
    endtask

    // query text builders
    task automatic add_text(input string s, input bit mixcase);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mixcase && $urandom_range(0, 1))
                c = c ^ CASE_BIT;
            query_bytes.push_back(c);
        end
    endtask

    task automatic add_word(input int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++)
        begin
            c = CH_UP_A + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1))
                c = c ^ CASE_BIT;
            query_bytes.push_back(c);
        end
    endtask

    task automatic add_filler();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            query_bytes.push_back(blank_bytes[$urandom_range(0, 5)]);
        else if (pick == 1)
            repeat ($urandom_range(2, 4))
                query_bytes.push_back(blank_bytes[$urandom_range(0, 5)]);
        else if (pick == 2)
        begin
            add_text("--", 0);
            repeat ($urandom_range(0, 5))
                query_bytes.push_back(note_chars[$urandom_range(0, note_chars.len() - 1)]);
            query_bytes.push_back(CH_LF);
        end
        else
        begin
            add_text("/*", 0);
            repeat ($urandom_range(0, 5))
                query_bytes.push_back(note_chars[$urandom_range(0, note_chars.len() - 1)]);
            add_text("*/", 0);
        end
    endtask

    // turn the built text into beats, with stray idle markers mixed in
    task automatic queue_query(input bit end_alone, input int ignore_pct);
        beat_t b;
        for (int i = 0; i < query_bytes.size(); i++)
        begin
            if ($urandom_range(0, 99) < ignore_pct)
            begin
                b = '{ch: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b0};
                pending_beats.push_back(b);
                ignored_beats++;
            end
            b = '{ch: query_bytes[i], present: 1'b1,
                  last: (!end_alone && i == query_bytes.size() - 1)};
            pending_beats.push_back(b);
            real_beats++;
        end
        if (end_alone)
        begin
            b = '{ch: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b1};
            pending_beats.push_back(b);
            real_beats++;
        end
        query_bytes.delete();
        queries++;
    endtask

    // sender with bursts and gaps, receiver with its own stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    next_beat = pending_beats.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'b0, next_beat.present, next_beat.ch};
                    s_tlast   <= next_beat.last;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
            beat_taken = 0;

            if (stall_age == 0)
                stall_bits = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                         : 16'($urandom) | 16'h0001;
            stall_age   = (stall_age + 1) % 64;
            m_tready    <= stall_bits[stall_phase];
            stall_phase = (stall_phase + 1) % 16;
        end
    end

    // accepted input beats feed the model, result beats are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                beat_taken = 1;
                classify_beat(s_tdata[7:0], s_tdata[8], s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("verdict beat with no query pending: tdata=%h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    query_verdict_t want;
                    want = expected_verdicts.pop_front();
                    if (m_tdata[3:0] !== want.verdict)
                    begin
                        $error("verdict: expected %0d, actual %0d", want.verdict, m_tdata[3:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[7:4] !== want.stype)
                    begin
                        $error("statement_type: expected %0d, actual %0d",
                               want.stype, m_tdata[7:4]);
                        mismatch_count++;
                    end
                    if (m_tdata[8] !== want.ro)
                    begin
                        $error("read_only: expected %0d, actual %0d", want.ro, m_tdata[8]);
                        mismatch_count++;
                    end
                    verdict_hits[want.verdict]++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, expected_verdicts.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int kw_pick;
        int forbidden;
        string w;
        beat_t stray;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        beat_taken  = 0;
        burst_left  = 0;
        gap_left    = 0;
        stall_bits  = 16'hffff;
        stall_phase = 0;
        stall_age   = 0;
        clear_query();

        // directed: empty query, open comments, injection, forbidden type,
        // marks cut by the end, top byte value, a stray idle marker
        queue_query(1, 0);
        add_text("--", 0);
        queue_query(0, 0);
        add_text("/*", 0);
        queue_query(0, 0);
        stray = '{ch: 8'h5a, present: 1'b0, last: 1'b0};
        pending_beats.push_back(stray);
        ignored_beats++;
        add_text("sElEcT;x", 0);
        queue_query(0, 0);
        add_text(" drop", 0);
        queue_query(0, 0);
        add_text("a-", 0);
        queue_query(1, 0);
        query_bytes.push_back(8'hff);
        queue_query(1, 0);

        // random queries, mostly keyword led with comments and spacing
        real_beats = 0;
        while (real_beats < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                // empty query
            end
            else if (pick < 20)
            begin
                repeat ($urandom_range(1, 10))
                begin
                    if ($urandom_range(0, 1))
                        query_bytes.push_back(8'($urandom_range(0, 255)));
                    else if ($urandom_range(0, 1))
                        query_bytes.push_back(note_chars[$urandom_range(0, note_chars.len() - 1)]);
                    else
                        query_bytes.push_back(blank_bytes[$urandom_range(0, 5)]);
                end
            end
            else
            begin
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
                    add_filler();
                kw_pick = $urandom_range(0, 99);
                if (kw_pick < 40)
                    add_text(kw_words[0], 1);
                else if (kw_pick < 70)
                    add_text(kw_words[$urandom_range(1, KW_COUNT - 1)], 1);
                else if (kw_pick < 80)
                begin
                    add_text(kw_words[$urandom_range(0, KW_COUNT - 1)], 1);
                    add_word($urandom_range(1, 2));
                end
                else if (kw_pick < 88)
                begin
                    w = kw_words[$urandom_range(0, KW_COUNT - 1)];
                    add_text(w.substr(0, w.len() - 2), 1);
                end
                else
                    add_word($urandom_range(1, 8));
                repeat ($urandom_range(0, 5))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick <= 2)
                        add_filler();
                    else if (pick == 3)
                        query_bytes.push_back(CH_SEMI);
                    else if (pick == 4)
                        add_text(" ; ", 0);
                    else if (pick == 5)
                        add_word($urandom_range(1, 6));
                    else if (pick == 6)
                        query_bytes.push_back(8'($urandom_range(0, 255)));
                    else if (pick == 7)
                        add_text(kw_words[$urandom_range(0, KW_COUNT - 1)], 1);
                    else if (pick == 8)
                        query_bytes.push_back(note_chars[$urandom_range(0, note_chars.len() - 1)]);
                    else
                    begin
                        query_bytes.push_back(CH_SEMI);
                        add_filler();
                    end
                end
            end
            queue_query(query_bytes.size() == 0 || $urandom_range(0, 2) == 0, 4);
        end

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain
        while (pending_beats.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        forbidden = 0;
        for (int i = 2; i <= 10; i++)
            forbidden += verdict_hits[i];
        $display("covered %0d queries in %0d stream beats plus %0d idle markers",
                 queries, real_beats, ignored_beats);
        $display("verdicts: %0d valid, %0d injection, %0d empty, %0d forbidden, %0d unknown",
                 verdict_hits[VERDICT_VALID], verdict_hits[VERDICT_INJECTION],
                 verdict_hits[VERDICT_EMPTY], forbidden, verdict_hits[VERDICT_UNKNOWN]);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
